### rtl/assert_macros.svh
// Assertion macros for the RTL file that carries concurrent checks (the top level).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/tmtw_pkg.sv
// Package: shared types and constants of the text console writer.
`default_nettype none

package tmtw_pkg;

  localparam int DEF_COLS = 80;
  localparam int DEF_ROWS = 25;

  localparam int CELL_W       = 16;
  localparam int CHAR_W       = 8;
  localparam int ATTR_W       = 8;
  localparam int CUR_ROW_W    = 5;
  localparam int CUR_COL_W    = 7;
  localparam int OP_W         = 2;
  localparam int IN_DATA_W    = 24;
  localparam int OUT_DATA_W   = 32;
  localparam int APB_ADDR_W   = 3;
  localparam int APB_DATA_W   = 32;

  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;
  localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_NL    = 8'd10;
  localparam logic [CHAR_W-1:0] CHAR_CR    = 8'd13;
  localparam logic [CHAR_W-1:0] CHAR_BS    = 8'd8;

  typedef enum logic [OP_W-1:0] {
    OP_PUT   = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  typedef enum logic {
    REG_ATTR   = 1'b0,
    REG_RENDER = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [ATTR_W-1:0] attr;
    logic              render_en;
  } cfg_t;

  typedef struct packed {
    logic [CUR_COL_W-1:0] cursor_col;
    logic [CUR_ROW_W-1:0] cursor_row;
    logic [ATTR_W-1:0]    cell_attr;
    logic [CHAR_W-1:0]    cell_char;
  } result_t;

endpackage

`default_nettype wire

### rtl/tmtw_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
`default_nettype none

module tmtw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/tmtw_regs.sv
// APB register block: text attribute and render enable.
`default_nettype none

module tmtw_regs (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [tmtw_pkg::APB_ADDR_W-1:0]  paddr,
  input  wire logic [tmtw_pkg::APB_DATA_W-1:0]  pwdata,
  output logic      [tmtw_pkg::APB_DATA_W-1:0]  prdata,
  output logic                                  pready,
  output tmtw_pkg::cfg_t                        cfg
);

  import tmtw_pkg::*;

  reg_idx_t idx;
  logic     wr;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[2]);
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.attr      <= ATTR_RESET;
      cfg.render_en <= 1'b1;
    end else if (wr) begin
      case (idx)
        REG_ATTR:   cfg.attr      <= pwdata[ATTR_W-1:0];
        REG_RENDER: cfg.render_en <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_ATTR:   prdata = {{(APB_DATA_W-ATTR_W){1'b0}}, cfg.attr};
      REG_RENDER: prdata = {{(APB_DATA_W-1){1'b0}}, cfg.render_en};
      default:    prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

### rtl/tmtw_cons.sv
// Console sequencer: cursor, scroll offset, cell writes, fills and reads.
`default_nettype none

module tmtw_cons #(
  parameter int SCREEN_COLS = tmtw_pkg::DEF_COLS,
  parameter int SCREEN_ROWS = tmtw_pkg::DEF_ROWS,
  localparam int ADDR_W = $clog2(SCREEN_COLS * SCREEN_ROWS)
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire tmtw_pkg::cfg_t                  cfg,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [tmtw_pkg::OP_W-1:0]       in_op,
  input  wire logic [tmtw_pkg::CHAR_W-1:0]     in_char,
  input  wire logic [tmtw_pkg::CUR_ROW_W-1:0]  in_row,
  input  wire logic [tmtw_pkg::CUR_COL_W-1:0]  in_col,
  output logic                                 ram_we,
  output logic      [ADDR_W-1:0]               ram_waddr,
  output logic      [tmtw_pkg::CELL_W-1:0]     ram_wdata,
  output logic                                 ram_re,
  output logic      [ADDR_W-1:0]               ram_raddr,
  input  wire logic [tmtw_pkg::CELL_W-1:0]     ram_rdata,
  output logic                                 res_valid,
  input  wire logic                            res_ready,
  output tmtw_pkg::result_t                    res
);

  import tmtw_pkg::*;

  localparam int ROW_W = $clog2(SCREEN_ROWS);
  localparam int COL_W = $clog2(SCREEN_COLS);
  localparam int CELLS = SCREEN_ROWS * SCREEN_COLS;
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(SCREEN_ROWS - 1);
  localparam logic [COL_W-1:0] COL_LAST = COL_W'(SCREEN_COLS - 1);
  localparam logic [ROW_W:0]   ROWS_X   = (ROW_W+1)'(SCREEN_ROWS);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_READ = 4'b0010,
    ST_FILL = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  state_t state;

  // top holds the physical row shown as screen row 0; scrolling bumps it
  logic [ROW_W-1:0]  cur_row, row_next, top, top_next;
  logic [COL_W-1:0]  cur_col, col_next;
  logic [ADDR_W-1:0] fill_addr, fill_end;
  logic [CELL_W-1:0] fill_data;
  logic              fill_emit;
  logic [CHAR_W-1:0] res_char;
  logic [ATTR_W-1:0] res_attr;

  logic              accept, put_go, do_nl, scroll, wr_char, rd_in_range;
  logic [ROW_W:0]    sum_cur, sum_rd;
  logic [ROW_W-1:0]  phys_cur, phys_rd;
  logic [ADDR_W-1:0] cur_addr, rd_addr, scroll_base;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign put_go   = accept && (in_op == OP_PUT) && cfg.render_en;

  // logical to physical row: add the scroll offset modulo the row count
  assign sum_cur  = {1'b0, cur_row} + {1'b0, top};
  assign phys_cur = (sum_cur >= ROWS_X) ? ROW_W'(sum_cur - ROWS_X) : ROW_W'(sum_cur);
  assign sum_rd   = {1'b0, ROW_W'(in_row)} + {1'b0, top};
  assign phys_rd  = (sum_rd >= ROWS_X) ? ROW_W'(sum_rd - ROWS_X) : ROW_W'(sum_rd);

  assign cur_addr    = ADDR_W'(phys_cur) * ADDR_W'(SCREEN_COLS) + ADDR_W'(cur_col);
  assign rd_addr     = ADDR_W'(phys_rd) * ADDR_W'(SCREEN_COLS) + ADDR_W'(in_col);
  assign scroll_base = ADDR_W'(top) * ADDR_W'(SCREEN_COLS);

  assign rd_in_range = (32'(in_row) < SCREEN_ROWS) && (32'(in_col) < SCREEN_COLS);

  always_comb begin
    row_next = cur_row;
    col_next = cur_col;
    top_next = top;
    do_nl    = 1'b0;
    wr_char  = 1'b0;
    scroll   = 1'b0;
    if (put_go) begin
      case (in_char)
        CHAR_NL: do_nl = 1'b1;
        CHAR_CR: col_next = '0;
        CHAR_BS: begin
          if (cur_col != '0) col_next = cur_col - 1'b1;
        end
        default: begin
          wr_char = 1'b1;
          if (cur_col == COL_LAST) do_nl = 1'b1;
          else col_next = cur_col + 1'b1;
        end
      endcase
      if (do_nl) begin
        col_next = '0;
        if (cur_row == ROW_LAST) begin
          // old top row becomes the new bottom row and gets blanked
          scroll   = 1'b1;
          top_next = (top == ROW_LAST) ? '0 : top + 1'b1;
        end else begin
          row_next = cur_row + 1'b1;
        end
      end
    end
  end

  // one item in flight at a time, so a read never meets a pending write
  assign ram_we    = (state == ST_FILL) || wr_char;
  assign ram_waddr = (state == ST_FILL) ? fill_addr : cur_addr;
  assign ram_wdata = (state == ST_FILL) ? fill_data : {cfg.attr, in_char};
  assign ram_re    = accept && (in_op == OP_READ) && rd_in_range;
  assign ram_raddr = rd_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_FILL;
      fill_addr <= '0;
      fill_end  <= ADDR_W'(CELLS - 1);
      fill_data <= {ATTR_RESET, BLANK_CHAR};
      fill_emit <= 1'b0;
      cur_row   <= '0;
      cur_col   <= '0;
      top       <= '0;
      res_char  <= '0;
      res_attr  <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            res_char <= '0;
            res_attr <= '0;
            case (in_op)
              OP_PUT: begin
                cur_row <= row_next;
                cur_col <= col_next;
                top     <= top_next;
                if (scroll) begin
                  fill_addr <= scroll_base;
                  fill_end  <= scroll_base + ADDR_W'(SCREEN_COLS - 1);
                  fill_data <= {cfg.attr, BLANK_CHAR};
                  fill_emit <= 1'b1;
                  state     <= ST_FILL;
                end else begin
                  state <= ST_EMIT;
                end
              end
              OP_READ: state <= rd_in_range ? ST_READ : ST_EMIT;
              OP_CLEAR: begin
                cur_row   <= '0;
                cur_col   <= '0;
                top       <= '0;
                fill_addr <= '0;
                fill_end  <= ADDR_W'(CELLS - 1);
                fill_data <= {cfg.attr, BLANK_CHAR};
                fill_emit <= 1'b1;
                state     <= ST_FILL;
              end
              default: state <= ST_EMIT;
            endcase
          end
        end
        ST_READ: begin
          res_char <= ram_rdata[CHAR_W-1:0];
          res_attr <= ram_rdata[CELL_W-1:CHAR_W];
          state    <= ST_EMIT;
        end
        ST_FILL: begin
          fill_addr <= fill_addr + 1'b1;
          if (fill_addr == fill_end) begin
            state <= fill_emit ? ST_EMIT : ST_IDLE;
          end
        end
        ST_EMIT: begin
          if (res_ready) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign res_valid      = (state == ST_EMIT);
  assign res.cell_char  = res_char;
  assign res.cell_attr  = res_attr;
  assign res.cursor_row = CUR_ROW_W'(cur_row);
  assign res.cursor_col = CUR_COL_W'(cur_col);

endmodule

`default_nettype wire

### rtl/text_mode_terminal_writer_unit.sv
// Text console writer: top level with APB registers, cell RAM and output register.
//
// Input stream (s_axis): one transfer per operation. tuser carries the op
// (put character, read cell, clear screen); tdata carries the character and
// the row/column of a cell to read. Output stream (m_axis): exactly one
// transfer per input, with the cell read (zero unless a read) and the cursor.
// Config: APB, text attribute at 0x0, render enable at 0x4; write only while idle.
// Sequence: a plain put passes through the emit state into the output register,
// and s_axis_tready is back in the cycle the result lands there; a read adds a
// state for the registered read of the cell RAM. One item is in work at a time.
// A line feed past the bottom row blanks one row of the RAM; a clear writes the
// whole RAM. Scrolling moves a row offset instead of copying cells.
// Reset: cursor homes and the RAM is swept to blank cells (space, attribute
// 0x0F); s_axis_tready stays low during the sweep, APB writes still land.
// Stall: a finished result sits in the output register; the next item can be
// accepted meanwhile and its result waits until the register is taken.
`default_nettype none

`include "assert_macros.svh"

module text_mode_terminal_writer_unit #(
  parameter int SCREEN_COLS = tmtw_pkg::DEF_COLS,
  parameter int SCREEN_ROWS = tmtw_pkg::DEF_ROWS
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // APB
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [tmtw_pkg::APB_ADDR_W-1:0]  paddr,
  input  wire logic [tmtw_pkg::APB_DATA_W-1:0]  pwdata,
  output logic      [tmtw_pkg::APB_DATA_W-1:0]  prdata,
  output logic                                  pready,
  // input stream
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // char_code[7:0], cell_row[12:8], cell_col[19:13], zero [23:20]
  input  wire logic [tmtw_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // operation[1:0]
  input  wire logic [tmtw_pkg::OP_W-1:0]        s_axis_tuser,
  // output stream
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // cell_char[7:0], cell_attr[15:8], cursor_row[20:16], cursor_col[27:21], zero [31:28]
  output logic      [tmtw_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

  import tmtw_pkg::*;

  localparam int ADDR_W = $clog2(SCREEN_COLS * SCREEN_ROWS);
  localparam int RES_W  = $bits(result_t);

  cfg_t              cfg;
  result_t           res, m_res;
  logic              res_valid, res_ready;
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [CELL_W-1:0] ram_wdata, ram_rdata;

  tmtw_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tmtw_cons #(
    .SCREEN_COLS (SCREEN_COLS),
    .SCREEN_ROWS (SCREEN_ROWS)
  ) u_cons (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_op     (s_axis_tuser),
    .in_char   (s_axis_tdata[7:0]),
    .in_row    (s_axis_tdata[12:8]),
    .in_col    (s_axis_tdata[19:13]),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  tmtw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (SCREEN_COLS * SCREEN_ROWS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // output register
  assign res_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_axis_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_res <= res;
    end
  end

  assign m_axis_tdata = {{(OUT_DATA_W-RES_W){1'b0}}, m_res};

  `ASSERT_NEXT(a_res_lands, clk, rst, res_valid && res_ready, m_axis_tvalid,
    "handed-off result did not reach the output register")
  `ASSERT_NEXT(a_busy_after_accept, clk, rst, s_axis_tvalid && s_axis_tready,
    !s_axis_tready, "accepted a second item while one was in work")
  `ASSERT_IMPL(a_cursor_range, clk, rst, m_axis_tvalid,
    (32'(m_res.cursor_col) < SCREEN_COLS) && (32'(m_res.cursor_row) < SCREEN_ROWS),
    "cursor left the screen")

endmodule

`default_nettype wire
